// ===== src/kpr_pkg.sv =====
package kpr_pkg;

    // Field and datapath widths
    localparam int IDX_W      = 11;
    localparam int SAMPLE_W   = 32;
    localparam int GRID_CFG_W = 12;
    localparam int TURN_W     = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;

    // Gain compensation: sample times K in Q32, then shift down to Q24
    localparam logic [31:0] GAIN_Q32   = 32'd2608131496;
    localparam int          GAIN_W     = 33;
    localparam int          PROD_W     = SAMPLE_W + GAIN_W;
    localparam int          GUARD      = 24;
    localparam int          XY_W       = 58;
    localparam int          Z_W        = TURN_W;
    localparam int          PC_HALF_W  = TURN_W / 2;

    // Defaults for the top-level parameters
    localparam int GRID_MAX_DEF      = 2048;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int GRID_MIN          = 2;
    localparam logic [GRID_CFG_W-1:0] GRID_RESET = 12'd2048;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COEF = 1'b1;

    // Output rounding and saturation limits
    localparam logic signed [XY_W-1:0] ROUND_HALF =
        {{(XY_W-GUARD){1'b0}}, 1'b1, {(GUARD-1){1'b0}}};
    localparam logic signed [XY_W-1:0] SAT_HI = {{(XY_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XY_W-1:0] SAT_LO = {{(XY_W-31){1'b1}}, {31{1'b0}}};

    // Vector handed from cell to cell
    typedef struct packed {
        logic            valid;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [Z_W-1:0]  z;
    } kpr_vec_t;

    // Restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q60, Taylor series with truncated terms
    function automatic logic [63:0] atan_recip_q60(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] term;
        p   = udiv64(64'd1 << 60, m);
        sum = '0;
        k   = '0;
        while (p != 64'd0) begin
            term = udiv64(p, (k << 1) + 64'd1);
            if (k[0] == 1'b0) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            p = udiv64(p, m * m);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // CORDIC stage angle, round(atan(2^-i) / 2pi * 2^48)
    function automatic logic [Z_W-1:0] stage_angle(input int i);
        logic [63:0] two_pi;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] term;
        int          k;
        int          b;
        if (i == 0) begin
            return Z_W'(64'd1 << 45);
        end
        two_pi = 64'd8 * (64'd4 * atan_recip_q60(64'd5) - atan_recip_q60(64'd239));
        a = '0;
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            term = udiv64(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
            if ((k % 2) == 0) begin
                a = a + term;
            end else begin
                a = a - term;
            end
        end
        rem = a;
        q   = '0;
        for (b = 0; b < TURN_W + 1; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= two_pi) begin
                rem = rem - two_pi;
                q   = q | 64'd1;
            end
        end
        q = (q + 64'd1) >> 1;
        return q[Z_W-1:0];
    endfunction

    // Round half up, drop guard bits, saturate to 32 bits
    function automatic logic [SAMPLE_W-1:0] finish(input logic [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-1:0] r;
        s = $signed(v) + ROUND_HALF;
        r = s >>> GUARD;
        if (r > SAT_HI) begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (r < SAT_LO) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== src/kpr_cordic_cell.sv =====
module kpr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  kpr_pkg::kpr_vec_t vec_in,
    output kpr_pkg::kpr_vec_t vec_out
);

    localparam logic signed [kpr_pkg::Z_W-1:0] ANGLE = kpr_pkg::stage_angle(STAGE);

    logic signed [kpr_pkg::XY_W-1:0] x_in;
    logic signed [kpr_pkg::XY_W-1:0] y_in;
    logic signed [kpr_pkg::Z_W-1:0]  z_in;
    logic signed [kpr_pkg::XY_W-1:0] dx;
    logic signed [kpr_pkg::XY_W-1:0] dy;
    logic                            valid_reg;
    logic                            valid_next;
    logic [kpr_pkg::XY_W-1:0]        x_reg, x_next;
    logic [kpr_pkg::XY_W-1:0]        y_reg, y_next;
    logic [kpr_pkg::Z_W-1:0]         z_reg, z_next;

    assign x_in = $signed(vec_in.x);
    assign y_in = $signed(vec_in.y);
    assign z_in = $signed(vec_in.z);
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;

    // One micro-rotation: sign of the residual picks the direction
    always_comb begin
        valid_next = vec_in.valid;
        if (z_in >= 0) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign vec_out = '{valid: valid_reg, x: x_reg, y: y_reg, z: z_reg};

endmodule

// ===== src/kpr_phase_front.sv =====
module kpr_phase_front #(
    parameter int GRID_MAX = kpr_pkg::GRID_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               ce,
    input  logic                               in_valid,
    input  logic [kpr_pkg::IDX_W-1:0]          row_index,
    input  logic [kpr_pkg::IDX_W-1:0]          col_index,
    input  logic [kpr_pkg::SAMPLE_W-1:0]       sample_re,
    input  logic [kpr_pkg::SAMPLE_W-1:0]       sample_im,
    input  logic [kpr_pkg::GRID_CFG_W-1:0]     grid_size,
    input  logic [kpr_pkg::TURN_W-1:0]         phase_coef,
    output kpr_pkg::kpr_vec_t                  vec_out
);

    localparam int N_W     = $clog2(GRID_MAX + 1);
    localparam int CMP_W   = (N_W > kpr_pkg::GRID_CFG_W) ? N_W : kpr_pkg::GRID_CFG_W;
    localparam int FREQ_W  = ((kpr_pkg::IDX_W > N_W) ? kpr_pkg::IDX_W : N_W) + 1;
    localparam int SQ_W    = 2 * FREQ_W;
    localparam int HW      = kpr_pkg::PC_HALF_W;
    localparam int MUL_W   = HW + SQ_W;
    localparam int XY_W    = kpr_pkg::XY_W;
    localparam int TURN_W  = kpr_pkg::TURN_W;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [TURN_W-1:0] EIGHTH_TURN = {3'b001, {(TURN_W-3){1'b0}}};

    // Effective grid size and wrap point
    logic [CMP_W-1:0]  gs_ext;
    logic [N_W-1:0]    n_eff;
    logic [FREQ_W-1:0] n_ext;
    logic [FREQ_W-1:0] half_ext;

    always_comb begin
        gs_ext = CMP_W'(grid_size);
        if (gs_ext < CMP_W'(kpr_pkg::GRID_MIN)) begin
            n_eff = N_W'(kpr_pkg::GRID_MIN);
        end else if (gs_ext > CMP_W'(GRID_MAX)) begin
            n_eff = N_W'(GRID_MAX);
        end else begin
            n_eff = N_W'(gs_ext);
        end
        n_ext    = FREQ_W'(n_eff);
        half_ext = FREQ_W'(n_eff >> 1);
    end

    // Stage 1: signed frequencies and gain-compensated sample
    logic [FREQ_W-1:0]            row_ext, col_ext;
    logic signed [kpr_pkg::PROD_W-1:0] prod_re, prod_im;
    logic                         s1_valid_reg;
    logic [FREQ_W-1:0]            s1_fi_reg, s1_fi_next;
    logic [FREQ_W-1:0]            s1_fj_reg, s1_fj_next;
    logic [XY_W-1:0]              s1_x_reg, s1_x_next;
    logic [XY_W-1:0]              s1_y_reg, s1_y_next;

    always_comb begin
        row_ext    = FREQ_W'(row_index);
        col_ext    = FREQ_W'(col_index);
        s1_fi_next = (row_ext < half_ext) ? row_ext : row_ext - n_ext;
        s1_fj_next = (col_ext < half_ext) ? col_ext : col_ext - n_ext;
        prod_re    = $signed(sample_re) * $signed({1'b0, kpr_pkg::GAIN_Q32});
        prod_im    = $signed(sample_im) * $signed({1'b0, kpr_pkg::GAIN_Q32});
        s1_x_next  = {prod_re[kpr_pkg::PROD_W-1], prod_re[kpr_pkg::PROD_W-1:8]};
        s1_y_next  = {prod_im[kpr_pkg::PROD_W-1], prod_im[kpr_pkg::PROD_W-1:8]};
    end

    // Stage 2: sum of squared frequencies
    logic signed [SQ_W-1:0] sq_i, sq_j;
    logic                   s2_valid_reg;
    logic [SQ_W-1:0]        s2_sq_reg, s2_sq_next;
    logic [XY_W-1:0]        s2_x_reg, s2_y_reg;

    always_comb begin
        sq_i       = $signed(s1_fi_reg) * $signed(s1_fi_reg);
        sq_j       = $signed(s1_fj_reg) * $signed(s1_fj_reg);
        s2_sq_next = $unsigned(sq_i) + $unsigned(sq_j);
    end

    // Stage 3: coefficient times square sum, split in two halves
    logic [MUL_W-1:0]  mul_lo, mul_hi;
    logic              s3_valid_reg;
    logic [TURN_W-1:0] s3_lo_reg, s3_lo_next;
    logic [HW-1:0]     s3_hi_reg, s3_hi_next;
    logic [XY_W-1:0]   s3_x_reg, s3_y_reg;

    always_comb begin
        mul_lo     = MUL_W'(phase_coef[HW-1:0]) * MUL_W'(s2_sq_reg);
        mul_hi     = MUL_W'(phase_coef[TURN_W-1:HW]) * MUL_W'(s2_sq_reg);
        s3_lo_next = mul_lo[TURN_W-1:0];
        s3_hi_next = mul_hi[HW-1:0];
    end

    // Stage 4: phase modulo one turn
    logic              s4_valid_reg;
    logic [TURN_W-1:0] s4_theta_reg, s4_theta_next;
    logic [XY_W-1:0]   s4_x_reg, s4_y_reg;

    assign s4_theta_next = s3_lo_reg + {s3_hi_reg, {HW{1'b0}}};

    // Stage 5: negate, pick quadrant, pre-rotate by whole quarter turns
    logic [TURN_W-1:0]          phi, phi_off;
    logic [1:0]                 quad;
    logic signed [TURN_W-1:0]   z5;
    logic [XY_W-1:0]            x5, y5;
    logic                       vec_valid_reg;
    kpr_pkg::kpr_vec_t          vec_reg, vec_next;

    always_comb begin
        phi     = '0 - s4_theta_reg;
        phi_off = phi + EIGHTH_TURN;
        quad    = phi_off[TURN_W-1:TURN_W-2];
        z5      = $signed({2'b00, phi_off[TURN_W-3:0]}) - $signed(EIGHTH_TURN);
        unique case (quad)
            QUAD_0: begin
                x5 = s4_x_reg;
                y5 = s4_y_reg;
            end
            QUAD_1: begin
                x5 = '0 - s4_y_reg;
                y5 = s4_x_reg;
            end
            QUAD_2: begin
                x5 = '0 - s4_x_reg;
                y5 = '0 - s4_y_reg;
            end
            QUAD_3: begin
                x5 = s4_y_reg;
                y5 = '0 - s4_x_reg;
            end
            default: begin
                x5 = s4_x_reg;
                y5 = s4_y_reg;
            end
        endcase
        vec_next = '{valid: s4_valid_reg, x: x5, y: y5, z: z5};
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            vec_valid_reg <= 1'b0;
        end else if (ce) begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            vec_valid_reg <= vec_next.valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_fi_reg    <= s1_fi_next;
            s1_fj_reg    <= s1_fj_next;
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s2_sq_reg    <= s2_sq_next;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s3_lo_reg    <= s3_lo_next;
            s3_hi_reg    <= s3_hi_next;
            s3_x_reg     <= s2_x_reg;
            s3_y_reg     <= s2_y_reg;
            s4_theta_reg <= s4_theta_next;
            s4_x_reg     <= s3_x_reg;
            s4_y_reg     <= s3_y_reg;
            vec_reg      <= vec_next;
        end
    end

    assign vec_out = '{valid: vec_valid_reg, x: vec_reg.x, y: vec_reg.y, z: vec_reg.z};

endmodule

// ===== src/kinetic_phase_rotation_core.sv =====
// Kinetic phase rotation for split-step Fourier solvers. Each input beat
// carries a momentum-space sample and its row and column; the block maps the
// indexes to signed frequencies, scales their squared sum by phase_coef
// (0.48 turns), and rotates the sample by minus that phase through a chain of
// CORDIC_STAGES rotation cells with gain compensated, rounding and saturating
// to 32 bits. One beat is accepted every clock when the output is taken.
// The pipe has five front stages (index mapping, squaring, the split 48-bit
// phase multiply, phase wrap, quadrant pre-rotation), one register per
// CORDIC cell and one output register. A two-entry output buffer keeps
// s_tready registered; it drops only once a result arrives in an output
// stall. Configuration must be written through the plain write port only
// while the block is idle; the block itself does not enforce this.
module kinetic_phase_rotation_core #(
    parameter int GRID_MAX      = kpr_pkg::GRID_MAX_DEF,
    parameter int CORDIC_STAGES = kpr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: row_index[10:0], col_index[21:11], sample_re[53:22], sample_im[85:54]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [kpr_pkg::IN_DATA_W-1:0]      s_tdata,
    // m_tdata: rotated_re[31:0], rotated_im[63:32]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kpr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_we,
    input  logic [kpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int IW = kpr_pkg::IDX_W;
    localparam int SW = kpr_pkg::SAMPLE_W;

    // Configuration registers
    logic [kpr_pkg::GRID_CFG_W-1:0] grid_size_reg;
    logic [kpr_pkg::TURN_W-1:0]     phase_coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= kpr_pkg::GRID_RESET;
            phase_coef_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kpr_pkg::CFG_GRID_SIZE:  grid_size_reg  <= cfg_wdata[kpr_pkg::GRID_CFG_W-1:0];
                kpr_pkg::CFG_PHASE_COEF: phase_coef_reg <= cfg_wdata[kpr_pkg::TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output buffer has room
    logic ce;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic [kpr_pkg::OUT_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic [kpr_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    // Front end and cell chain
    kpr_pkg::kpr_vec_t cell_vec [0:CORDIC_STAGES];

    kpr_phase_front #(
        .GRID_MAX (GRID_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (s_tvalid),
        .row_index  (s_tdata[IW-1:0]),
        .col_index  (s_tdata[2*IW-1:IW]),
        .sample_re  (s_tdata[2*IW+SW-1:2*IW]),
        .sample_im  (s_tdata[2*IW+2*SW-1:2*IW+SW]),
        .grid_size  (grid_size_reg),
        .phase_coef (phase_coef_reg),
        .vec_out    (cell_vec[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        kpr_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .vec_in  (cell_vec[g]),
            .vec_out (cell_vec[g+1])
        );
    end

    // Round, saturate and buffer the result
    logic                           last_valid;
    logic [kpr_pkg::OUT_DATA_W-1:0] fin_data;

    assign last_valid = cell_vec[CORDIC_STAGES].valid;
    assign fin_data   = {kpr_pkg::finish(cell_vec[CORDIC_STAGES].y),
                         kpr_pkg::finish(cell_vec[CORDIC_STAGES].x)};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = last_valid;
                out_data_next   = fin_data;
            end
        end else if (ce && last_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = fin_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Buffer only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer full with no result on the output");

    // A result leaving the chain during an output stall is caught
    a_stall_caught: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && ce && last_valid) |=> skid_valid_reg)
        else $error("result lost during output stall");

    // Buffered result moves to the output once taken
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid buffer did not drain");

endmodule

// ===== tb/tb_kinetic_phase_rotation_core.sv =====
`timescale 1ns / 1ps

module tb_kinetic_phase_rotation_core;

    localparam int     GRID_LIMIT   = kpr_pkg::GRID_MAX_DEF;
    localparam int     STAGES       = kpr_pkg::CORDIC_STAGES_DEF;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     TAIL_CYCLES  = kpr_pkg::CORDIC_STAGES_DEF + 16;
    localparam int     RANDOM_SETS  = 2;
    localparam int     SET_BEATS    = 56;
    localparam logic [63:0] TURN_MASK    = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint      GAIN_SCALE   = 64'sd2608131496;
    localparam longint      HALF_LSB     = 64'sd8388608;
    localparam longint      RESULT_MAX   = 64'sd2147483647;
    localparam longint      RESULT_MIN   = -64'sd2147483648;
    localparam logic [47:0] COEF_FULL    = 48'hFFFF_FFFF_FFFF;

    // Coarse rotation applied ahead of the CORDIC cells
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quadrant_t;

    typedef struct {
        logic [10:0]        row;
        logic [10:0]        col;
        logic signed [31:0] re;
        logic signed [31:0] im;
    } sample_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } rotated_t;

    typedef struct {
        bit          load_cfg;
        logic [11:0] grid;
        logic [47:0] coef;
        logic [10:0] row;
        logic [10:0] col;
        logic [31:0] re;
        logic [31:0] im;
        bit          typed;
        logic [31:0] want_re;
        logic [31:0] want_im;
    } directed_row_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [kpr_pkg::IN_DATA_W-1:0]    s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [kpr_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             cfg_we    = 1'b0;
    logic [kpr_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [kpr_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

    // Shadow of the block's settings, as last written
    logic [11:0] grid_reg = kpr_pkg::GRID_RESET;
    logic [47:0] coef_reg = '0;

    longint   turn_angle [STAGES];
    rotated_t rotation_due [$];
    rotated_t oldest;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;

    int SEND_IDLE  [4] = '{0, 80, 0, 12};
    int RECV_STALL [4] = '{0, 0, 80, 12};

    // Directed beats; zero samples stay zero whatever the phase
    directed_row_t directed_rows [22] = '{
        // after reset: grid 2048, no phase
        '{1'b0, 12'd0, 48'd0, 11'd0, 11'd0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd0, 11'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd2047, 11'd2047, 32'h80000000, 32'h80000000, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1024, 11'd1023, 32'h7FFFFFFF, 32'h80000000, 1'b0,
          32'h0, 32'h0},
        // grid below minimum, quarter turn per unit
        '{1'b1, 12'd0, 48'h4000_0000_0000, 11'd0, 11'd1, 32'h40000000, 32'h0, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1, 11'd1, 32'h12345678, 32'hEDCBA988, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd2047, 11'd0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd5, 11'd3, 32'h7FFFFFFF, 32'h0, 1'b0, 32'h0, 32'h0},
        // grid above limit, full-scale coefficient: phase wraps
        '{1'b1, 12'd4095, COEF_FULL, 11'd2047, 11'd2047, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1, 11'd0, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd0, 11'd0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
        // grid of one acts as two, eighth turn
        '{1'b1, 12'd1, 48'h2000_0000_0000, 11'd1, 11'd0, 32'h00001234, 32'hFFFFE9D2, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1, 11'd1, 32'h80000000, 32'h80000000, 1'b0, 32'h0, 32'h0},
        // odd grid, half rounds down; indexes past the grid
        '{1'b1, 12'd5, 48'h9000_0000_0000, 11'd2, 11'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1, 11'd4, 32'h00000001, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd7, 11'd2047, 32'h55555555, 32'hAAAAAAAA, 1'b0,
          32'h0, 32'h0},
        // full grid, arbitrary coefficient
        '{1'b1, 12'd2048, 48'h1234_5678_9ABC, 11'd1024, 11'd1024, 32'h7FFFFFFF,
          32'h80000000, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd1023, 11'd0, 32'hFFFFFFFF, 32'h00000001, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd0, 11'd0, 32'h00000001, 32'h00000001, 1'b0, 32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd0, 11'd0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
        // one past the limit, smallest step
        '{1'b1, 12'd2049, 48'd1, 11'd2047, 11'd1, 32'hC0000000, 32'h3FFFFFFF, 1'b0,
          32'h0, 32'h0},
        '{1'b0, 12'd0, 48'd0, 11'd3, 11'd3, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0}
    };

    kinetic_phase_rotation_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // atan(1/m) in Q60 by its series, every term truncated
    function automatic logic [63:0] arctan_inv_q60(input logic [63:0] m);
        logic [63:0] pw;
        logic [63:0] acc;
        logic [63:0] k;
        pw  = (64'd1 << 60) / m;
        acc = '0;
        k   = '0;
        while (pw != 64'd0) begin
            if (k[0]) begin
                acc = acc - pw / ((k << 1) + 64'd1);
            end else begin
                acc = acc + pw / ((k << 1) + 64'd1);
            end
            pw = pw / (m * m);
            k  = k + 64'd1;
        end
        return acc;
    endfunction

    // Stage angles in 0.48 turns, rounded to nearest
    initial begin
        logic [63:0] two_pi;
        logic [63:0] arc;
        logic [63:0] rem;
        logic [63:0] quo;
        int          i;
        int          k;
        int          b;
        two_pi = 64'd8 * (64'd4 * arctan_inv_q60(64'd5) - arctan_inv_q60(64'd239));
        turn_angle[0] = 64'sd1 <<< 45;
        for (i = 1; i < STAGES; i++) begin
            arc = '0;
            for (k = 0; i * (2 * k + 1) <= 60; k++) begin
                if (k % 2 == 0) begin
                    arc = arc + (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                end else begin
                    arc = arc - (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                end
            end
            rem = arc;
            quo = '0;
            for (b = 0; b < 49; b++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= two_pi) begin
                    rem = rem - two_pi;
                    quo = quo | 64'd1;
                end
            end
            turn_angle[i] = longint'((quo + 64'd1) >> 1);
        end
    end

    function automatic longint grid_in_use();
        longint n;
        n = grid_reg;
        if (n < kpr_pkg::GRID_MIN) n = kpr_pkg::GRID_MIN;
        if (n > GRID_LIMIT) n = GRID_LIMIT;
        return n;
    endfunction

    function automatic longint signed_freq(input logic [10:0] idx, input longint n);
        longint k;
        k = idx;
        return (k < n / 2) ? k : k - n;
    endfunction

    function automatic logic signed [31:0] round_saturate(input longint v);
        longint r;
        r = (v + HALF_LSB) >>> kpr_pkg::GUARD;
        if (r > RESULT_MAX) return 32'h7FFFFFFF;
        if (r < RESULT_MIN) return 32'h80000000;
        return r[31:0];
    endfunction

    // Expected rotation of one sample under the current settings
    function automatic rotated_t predict_rotation(input sample_t smp);
        longint      n;
        longint      fr;
        longint      fc;
        logic [63:0] sq;
        logic [63:0] theta;
        logic [63:0] phi;
        logic [63:0] quad;
        logic [63:0] resid;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        longint      dx;
        longint      dy;
        int          i;
        rotated_t    res;
        n     = grid_in_use();
        fr    = signed_freq(smp.row, n);
        fc    = signed_freq(smp.col, n);
        sq    = fr * fr + fc * fc;
        theta = ({16'd0, coef_reg} * sq) & TURN_MASK;
        phi   = (64'd0 - theta) & TURN_MASK;
        quad  = ((phi + (64'd1 << 45)) >> 46) & 64'd3;
        resid = (phi - (quad << 46)) & TURN_MASK;
        z     = $signed(resid[47:0]);
        x     = (longint'(smp.re) * GAIN_SCALE) >>> (32 - kpr_pkg::GUARD);
        y     = (longint'(smp.im) * GAIN_SCALE) >>> (32 - kpr_pkg::GUARD);
        case (quadrant_t'(quad[1:0]))
            QUAD_90: begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_180: begin
                x = -x;
                y = -y;
            end
            QUAD_270: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        for (i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - turn_angle[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + turn_angle[i];
            end
        end
        res.re = round_saturate(x);
        res.im = round_saturate(y);
        return res;
    endfunction

    function automatic logic [10:0] pick_index();
        if ($urandom_range(9) < 7) return 11'($urandom_range(grid_in_use() - 1));
        return 11'($urandom_range(2047));
    endfunction

    function automatic logic [31:0] pick_part();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($urandom_range(511)) - 32'd256;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Hold the input low until every rotated beat is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (rotation_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [11:0] grid, input logic [47:0] coef,
                                 input logic [35:0] junk);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= kpr_pkg::CFG_GRID_SIZE;
        cfg_wdata <= {junk, grid};
        @(posedge aclk);
        cfg_index <= kpr_pkg::CFG_PHASE_COEF;
        cfg_wdata <= coef;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        grid_reg = grid;
        coef_reg = coef;
    endtask

    // One input beat; valid stays up on return so back-to-back beats need no gap
    task automatic send_sample(input sample_t smp, input bit typed, input rotated_t want);
        rotated_t due;
        if (typed) begin
            due = want;
        end else begin
            due = predict_rotation(smp);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, smp.im, smp.re, smp.col, smp.row};
        do @(posedge aclk); while (!s_tready);
        rotation_due.push_back(due);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each rotated beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rotation_due.size() == 0) begin
                $display("%0t: unexpected beat, re %0d im %0d", $time,
                         $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
                mismatch_count++;
            end else begin
                oldest = rotation_due.pop_front();
                if (m_tdata[31:0] !== oldest.re) begin
                    $display("%0t: rotated_re expected %0d got %0d", $time,
                             oldest.re, $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== oldest.im) begin
                    $display("%0t: rotated_im expected %0d got %0d", $time,
                             oldest.im, $signed(m_tdata[63:32]));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_kinetic_phase_rotation_core: errors");
            $finish;
        end
    end

    initial begin
        sample_t     smp;
        rotated_t    want;
        int          ph;
        int          setting;
        int          cnt;
        logic [11:0] grid_pick;
        logic [47:0] coef_pick;

        aresetn <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats
        foreach (directed_rows[r]) begin
            if (directed_rows[r].load_cfg) begin
                load_settings(directed_rows[r].grid, directed_rows[r].coef, 36'd0);
            end
            smp.row = directed_rows[r].row;
            smp.col = directed_rows[r].col;
            smp.re  = directed_rows[r].re;
            smp.im  = directed_rows[r].im;
            want.re = directed_rows[r].want_re;
            want.im = directed_rows[r].want_im;
            send_sample(smp, directed_rows[r].typed, want);
        end

        // Random beats over the idling phases and a spread of settings
        want.re = '0;
        want.im = '0;
        for (ph = 0; ph < 4; ph++) begin
            for (setting = 0; setting < RANDOM_SETS; setting++) begin
                case ($urandom_range(7))
                    0: grid_pick = 12'd0;
                    1: grid_pick = 12'd1;
                    2: grid_pick = 12'd2;
                    3: grid_pick = 12'd2048;
                    4: grid_pick = 12'd4095;
                    5: grid_pick = 12'($urandom_range(17, 3));
                    6: grid_pick = 12'($urandom_range(2048, 2));
                    default: grid_pick = 12'($urandom_range(4095, 2049));
                endcase
                case ($urandom_range(5))
                    0: coef_pick = '0;
                    1: coef_pick = COEF_FULL;
                    2: coef_pick = 48'd1 << $urandom_range(47);
                    default: coef_pick = 48'({$urandom, $urandom});
                endcase
                load_settings(grid_pick, coef_pick, 36'({$urandom, $urandom}));
                // new idling mix only once the pipe is empty
                send_idle_pct  = SEND_IDLE[ph];
                recv_stall_pct = RECV_STALL[ph];
                for (cnt = 0; cnt < SET_BEATS; cnt++) begin
                    if ((setting == 0 && cnt == SET_BEATS / 2) || $urandom_range(49) == 0) begin
                        drain_results();
                    end
                    smp.row = pick_index();
                    smp.col = pick_index();
                    smp.re  = pick_part();
                    smp.im  = pick_part();
                    send_sample(smp, 1'b0, want);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && rotation_due.size() == 0) begin
            $display("tb_kinetic_phase_rotation_core: clean");
        end else begin
            $display("tb_kinetic_phase_rotation_core: errors");
        end
        $finish;
    end

endmodule
